// File: rtl/core/tcc_pkg.sv
// Shared types, widths and constants of the toolpath continuity checker.
// Used by every file of the block; depends on nothing.
package tcc_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned LINE_BITS  = 24;
  localparam int unsigned THR_BITS   = 24;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
  localparam int unsigned SQ_BITS    = 2 * DIFF_BITS;
  localparam int unsigned D2_BITS    = SQ_BITS + 2;
  localparam int unsigned ROOT_BITS  = D2_BITS / 2;
  localparam int unsigned SUM_BITS   = 40;
  localparam int unsigned GAP_BITS   = 25;
  localparam int unsigned SCORE_BITS = 7;
  localparam int unsigned PEN_BITS   = COUNT_BITS + 5;
  localparam int unsigned NKIND      = 8;
  localparam int unsigned KIND_BITS  = 3;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [D2_BITS-1:0]    HIGH_GAP_SQ   = D2_BITS'(100000000);
  localparam logic [D2_BITS-1:0]    MED_GAP_SQ    = D2_BITS'(25000000);
  localparam logic [D2_BITS-1:0]    TURN_MIN_SQ   = D2_BITS'(10000);
  localparam logic [DIFF_BITS-1:0]  ZJUMP_UM      = DIFF_BITS'(5000);
  localparam logic [DIFF_BITS-1:0]  PLUNGE_UM     = DIFF_BITS'(500);
  localparam logic [COORD_BITS:0]   LAYER_RISE_UM = (COORD_BITS + 1)'(10);
  localparam logic [PEN_BITS-1:0]   SCORE_FULL    = PEN_BITS'(100);
  localparam logic [THR_BITS-1:0]   GAP_THR_RST   = THR_BITS'(2000);
  localparam logic [THR_BITS-1:0]   LAYER_THR_RST = THR_BITS'(1000);

  localparam logic [1:0] MODE_RAPID = 2'd0;
  localparam logic [1:0] MODE_FEED  = 2'd1;
  localparam logic       FUNC_FINISH = 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_THR   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER_THR = 1'b1;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_GAP         = 3'd0,
    KIND_ZJUMP       = 3'd1,
    KIND_RETRACT     = 3'd2,
    KIND_PLUNGE      = 3'd3,
    KIND_REVERSAL    = 3'd4,
    KIND_LAYER       = 3'd5,
    KIND_ISSUE_TALLY = 3'd6,
    KIND_LAYER_TALLY = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    SEV_LOW  = 2'd0,
    SEV_MED  = 2'd1,
    SEV_HIGH = 2'd2
  } sev_e;

  typedef struct packed {
    logic                          func;
    logic [LINE_BITS-1:0]          line;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
    logic signed [COORD_BITS-1:0]  extrude;
    logic                          has_extrude;
    logic [1:0]                    mode;
  } in_item_t;

  typedef struct packed {
    kind_e                         kind;
    sev_e                          severity;
    logic [LINE_BITS-1:0]          position;
    logic [SUM_BITS-1:0]           distance;
    logic [GAP_BITS-1:0]           max_gap;
    logic signed [COORD_BITS-1:0]  layer_z;
    logic [COUNT_BITS-1:0]         count_a;
    logic [COUNT_BITS-1:0]         count_b;
    logic [COUNT_BITS-1:0]         count_c;
    logic                          flag;
    logic [SCORE_BITS-1:0]         score;
    logic                          last;
  } out_item_t;

  // Classified move handed from the front to the back
  typedef struct packed {
    logic                          finish;
    logic [LINE_BITS-1:0]          line;
    logic                          gap;
    sev_e                          gap_sev;
    logic                          zjump;
    logic [DIFF_BITS-1:0]          dz_mag;
    logic                          retract;
    logic [DIFF_BITS-1:0]          ret_amt;
    logic                          plunge;
    logic                          rev;
    logic                          close;
    logic [LINE_BITS-1:0]          close_num;
    logic signed [COORD_BITS-1:0]  close_z;
    logic                          lgap;
    logic [D2_BITS-1:0]            d2;
    logic [D2_BITS-1:0]            xy2;
  } job_t;

  function automatic logic [DIFF_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] d);
    return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/tcc_if.sv
// Valid/ready channel interfaces for move requests and result records.
// Depends on tcc_pkg.
interface tcc_in_if;
  logic               valid;
  logic               ready;
  tcc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  tcc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tcc_front.sv
// Front part: accepts moves, forms deltas, squares and classifies them.
// Depends on tcc_pkg and tcc_if.
module tcc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tcc_in_if.sink                            in_i,
  input  logic [2*tcc_pkg::THR_BITS-1:0]    gap_thr_sq_i,
  input  logic [2*tcc_pkg::THR_BITS-1:0]    layer_thr_sq_i,
  input  logic                              full_i,
  output logic                              push_o,
  output tcc_pkg::job_t                     job_o
);
  localparam int unsigned CW = tcc_pkg::COORD_BITS;
  localparam int unsigned DW = tcc_pkg::DIFF_BITS;

  logic signed [CW-1:0] prev_x_q, prev_y_q, prev_z_q, prev_e_q;
  logic                 accept, move_in;
  logic signed [DW-1:0] dx_in, dy_in, dz_in;
  logic [DW-1:0]        dz_mag_in;

  logic                 a_valid_q;
  logic                 a_func_q, a_zjump_q, a_ret_q, a_plunge_q;
  logic [tcc_pkg::LINE_BITS-1:0] a_line_q;
  logic signed [DW-1:0] a_dx_q, a_dy_q;
  logic [DW-1:0]        a_dz_mag_q, a_ret_amt_q;
  logic signed [CW-1:0] a_z_q;
  logic [1:0]           a_mode_q;

  assign in_i.ready = !a_valid_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = a_valid_q && !full_i;
  assign move_in    = in_i.data.func != tcc_pkg::FUNC_FINISH;

  assign dx_in     = DW'(in_i.data.pos_x) - DW'(prev_x_q);
  assign dy_in     = DW'(in_i.data.pos_y) - DW'(prev_y_q);
  assign dz_in     = DW'(in_i.data.pos_z) - DW'(prev_z_q);
  assign dz_mag_in = tcc_pkg::mag(dz_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      prev_z_q  <= '0;
      prev_e_q  <= '0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (push_o) begin
        a_valid_q <= 1'b0;
      end
      if (accept) begin
        if (move_in) begin
          prev_x_q <= in_i.data.pos_x;
          prev_y_q <= in_i.data.pos_y;
          prev_z_q <= in_i.data.pos_z;
          prev_e_q <= in_i.data.extrude;
        end else begin
          prev_x_q <= '0;
          prev_y_q <= '0;
          prev_z_q <= '0;
          prev_e_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_func_q    <= !move_in;
      a_line_q    <= in_i.data.line;
      a_dx_q      <= dx_in;
      a_dy_q      <= dy_in;
      a_dz_mag_q  <= dz_mag_in;
      a_z_q       <= in_i.data.pos_z;
      a_mode_q    <= in_i.data.mode;
      a_zjump_q   <= move_in && in_i.data.mode != tcc_pkg::MODE_RAPID
                     && dz_mag_in > tcc_pkg::ZJUMP_UM;
      a_ret_q     <= move_in && in_i.data.has_extrude && in_i.data.extrude < prev_e_q;
      a_ret_amt_q <= DW'(prev_e_q) - DW'(in_i.data.extrude);
      a_plunge_q  <= move_in && dz_in[DW-1] && in_i.data.has_extrude
                     && in_i.data.extrude > prev_e_q && dz_mag_in > tcc_pkg::PLUNGE_UM;
    end
  end

  // Second step: squares, direction and layer tracking, evaluated as the job leaves
  logic signed [DW-1:0] dir_x_q, dir_y_q;
  logic                 dir_valid_q;
  logic [tcc_pkg::LINE_BITS-1:0] lnum_q;
  logic signed [CW-1:0] lz_q;

  logic [DW-1:0] mx, my, mdx, mdy;
  logic [tcc_pkg::SQ_BITS-1:0] sqx, sqy, sqz, px, py;
  logic [tcc_pkg::D2_BITS-1:0] xy2, d2;
  logic n1, n2, dot_neg, rapid, turn_move, rise, gap;
  logic signed [CW:0] z_ext, h_rise;

  assign mx  = tcc_pkg::mag(a_dx_q);
  assign my  = tcc_pkg::mag(a_dy_q);
  assign mdx = tcc_pkg::mag(dir_x_q);
  assign mdy = tcc_pkg::mag(dir_y_q);
  assign sqx = mx * mx;
  assign sqy = my * my;
  assign sqz = a_dz_mag_q * a_dz_mag_q;
  assign px  = mx * mdx;
  assign py  = my * mdy;
  assign xy2 = tcc_pkg::D2_BITS'(sqx) + tcc_pkg::D2_BITS'(sqy);
  assign d2  = xy2 + tcc_pkg::D2_BITS'(sqz);

  assign n1 = (px != '0) && (a_dx_q[DW-1] != dir_x_q[DW-1]);
  assign n2 = (py != '0) && (a_dy_q[DW-1] != dir_y_q[DW-1]);
  always_comb begin
    if (n1 && n2) begin
      dot_neg = 1'b1;
    end else if (n1) begin
      dot_neg = px > py;
    end else if (n2) begin
      dot_neg = py > px;
    end else begin
      dot_neg = 1'b0;
    end
  end

  assign rapid     = a_mode_q == tcc_pkg::MODE_RAPID;
  assign turn_move = !a_func_q && !rapid && d2 > tcc_pkg::TURN_MIN_SQ;
  assign gap       = !a_func_q && rapid && d2 > tcc_pkg::D2_BITS'(gap_thr_sq_i);
  assign z_ext     = (CW + 1)'(a_z_q);
  assign h_rise    = (CW + 1)'(lz_q) + tcc_pkg::LAYER_RISE_UM;
  assign rise      = (lnum_q != '0) && z_ext > h_rise;

  always_comb begin
    job_o           = '0;
    job_o.finish    = a_func_q;
    job_o.line      = a_line_q;
    job_o.gap       = gap;
    job_o.gap_sev   = (d2 > tcc_pkg::HIGH_GAP_SQ) ? tcc_pkg::SEV_HIGH :
                      (d2 > tcc_pkg::MED_GAP_SQ)  ? tcc_pkg::SEV_MED : tcc_pkg::SEV_LOW;
    job_o.zjump     = a_zjump_q;
    job_o.dz_mag    = a_dz_mag_q;
    job_o.retract   = a_ret_q;
    job_o.ret_amt   = a_ret_amt_q;
    job_o.plunge    = a_plunge_q;
    job_o.rev       = turn_move && dir_valid_q && (a_dx_q != '0 || a_dy_q != '0)
                      && (dir_x_q != '0 || dir_y_q != '0) && dot_neg;
    job_o.close     = a_func_q ? (lnum_q != '0) : rise;
    job_o.close_num = lnum_q;
    job_o.close_z   = lz_q;
    job_o.lgap      = !a_func_q && a_mode_q == tcc_pkg::MODE_FEED
                      && xy2 > tcc_pkg::D2_BITS'(layer_thr_sq_i);
    job_o.d2        = d2;
    job_o.xy2       = xy2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      dir_valid_q <= 1'b0;
      lnum_q      <= '0;
      lz_q        <= '0;
    end else if (push_o) begin
      if (a_func_q) begin
        dir_x_q     <= '0;
        dir_y_q     <= '0;
        dir_valid_q <= 1'b0;
        lnum_q      <= '0;
        lz_q        <= '0;
      end else begin
        if (turn_move) begin
          dir_x_q     <= a_dx_q;
          dir_y_q     <= a_dy_q;
          dir_valid_q <= 1'b1;
        end
        if (rise) begin
          lnum_q <= (lnum_q == '1) ? lnum_q : lnum_q + tcc_pkg::LINE_BITS'(1);
          lz_q   <= a_z_q;
        end else if (lnum_q == '0) begin
          lnum_q <= tcc_pkg::LINE_BITS'(1);
          lz_q   <= a_z_q;
        end
      end
    end
  end

endmodule

// File: rtl/core/tcc_queue.sv
// Short job queue between the front and the back.
// Depends on tcc_pkg.
module tcc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tcc_pkg::job_t data_o,
  output logic          empty_o
);
  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  tcc_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/tcc_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on tcc_pkg.
module tcc_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tcc_pkg::D2_BITS-1:0]     operand_i,
  output logic                            done_o,
  output logic [tcc_pkg::ROOT_BITS-1:0]   root_o
);
  localparam int unsigned RW = tcc_pkg::ROOT_BITS;
  localparam int unsigned OW = tcc_pkg::D2_BITS;
  localparam int unsigned CNTW = $clog2(RW);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [OW-1:0]   opnd_q;
  logic [RW+1:0]   rem_q, rem_next, trial;
  logic [RW-1:0]   root_q;

  assign rem_next = {rem_q[RW-1:0], opnd_q[OW-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign done_o   = done_q;
  assign root_o   = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= operand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      opnd_q <= {opnd_q[OW-3:0], 2'b00};
      if (rem_next >= trial) begin
        rem_q  <= rem_next - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_next;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/tcc_back.sv
// Back part: turns queued jobs into issue, layer and tally records.
// Depends on tcc_pkg, tcc_if and tcc_sqrt.
module tcc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcc_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  tcc_out_if.source     out_o
);
  localparam int unsigned NK = tcc_pkg::NKIND;
  localparam int unsigned CB = tcc_pkg::COUNT_BITS;
  localparam int unsigned SB = tcc_pkg::SUM_BITS;
  localparam int unsigned GB = tcc_pkg::GAP_BITS;
  localparam int unsigned PB = tcc_pkg::PEN_BITS;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_GAP_RT  = 4'b0010,
    ST_EMIT    = 4'b0100,
    ST_XY_RT   = 4'b1000
  } state_e;

  state_e st_q;
  tcc_pkg::job_t job_q;
  logic [NK-1:0] pend_q, pend_rest;
  tcc_pkg::kind_e sel;

  logic [CB-1:0] lay_gaps_q, high_q, med_q, low_q, layers_q, clean_q, all_gaps_q;
  logic [GB-1:0] lay_max_q, all_max_q, g;
  logic [SB-1:0] lay_sum_q, rapid_sum_q;

  logic                                  sq_start, sq_done;
  logic [tcc_pkg::D2_BITS-1:0]           sq_opnd;
  logic [tcc_pkg::ROOT_BITS-1:0]         root;
  logic                                  out_free, emit;
  logic [CB:0]                           gap_add;
  logic [PB-1:0]                         pen;
  tcc_pkg::out_item_t                    rec;
  tcc_pkg::out_item_t                    out_q;
  logic                                  out_valid_q;

  tcc_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sq_opnd),
    .done_o    (sq_done),
    .root_o    (root)
  );

  assign pop_o    = st_q == ST_IDLE && !empty_i;
  assign sq_opnd  = (st_q == ST_IDLE) ? job_i.d2 : job_q.xy2;
  assign sq_start = (pop_o && job_i.gap) || (st_q == ST_EMIT && pend_q == '0 && job_q.lgap);
  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = st_q == ST_EMIT && pend_q != '0 && out_free;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Lowest pending kind goes first; kind code doubles as the bit index
  always_comb begin
    sel = tcc_pkg::KIND_GAP;
    for (int i = NK - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = tcc_pkg::kind_e'(tcc_pkg::KIND_BITS'(i));
      end
    end
  end
  assign pend_rest = pend_q & ~(NK'(1) << sel);

  assign g       = root[tcc_pkg::ROOT_BITS-1:GB] != '0 ? '1 : root[GB-1:0];
  assign gap_add = {1'b0, all_gaps_q} + {1'b0, lay_gaps_q};
  assign pen     = PB'({high_q, 3'b000}) + PB'({high_q, 1'b0}) + PB'({med_q, 2'b00})
                   + PB'(med_q) + PB'(low_q);

  always_comb begin
    rec      = '0;
    rec.kind = sel;
    rec.last = pend_rest == '0;
    case (sel)
      tcc_pkg::KIND_GAP: begin
        rec.severity = job_q.gap_sev;
        rec.position = job_q.line;
        rec.distance = SB'(root);
      end
      tcc_pkg::KIND_ZJUMP: begin
        rec.severity = tcc_pkg::SEV_MED;
        rec.position = job_q.line;
        rec.distance = SB'(job_q.dz_mag);
      end
      tcc_pkg::KIND_RETRACT: begin
        rec.severity = tcc_pkg::SEV_LOW;
        rec.position = job_q.line;
        rec.distance = SB'(job_q.ret_amt);
      end
      tcc_pkg::KIND_PLUNGE: begin
        rec.severity = tcc_pkg::SEV_MED;
        rec.position = job_q.line;
        rec.distance = SB'(job_q.dz_mag);
      end
      tcc_pkg::KIND_REVERSAL: begin
        rec.severity = tcc_pkg::SEV_LOW;
        rec.position = job_q.line;
      end
      tcc_pkg::KIND_LAYER: begin
        rec.position = job_q.close_num;
        rec.distance = lay_sum_q;
        rec.max_gap  = lay_max_q;
        rec.layer_z  = job_q.close_z;
        rec.count_a  = lay_gaps_q;
        rec.flag     = lay_gaps_q == '0;
      end
      tcc_pkg::KIND_ISSUE_TALLY: begin
        rec.distance = rapid_sum_q;
        rec.count_a  = high_q;
        rec.count_b  = med_q;
        rec.count_c  = low_q;
        rec.flag     = high_q == '0;
        rec.score    = (pen >= tcc_pkg::SCORE_FULL) ? '0
                       : tcc_pkg::SCORE_BITS'(tcc_pkg::SCORE_FULL - pen);
      end
      tcc_pkg::KIND_LAYER_TALLY: begin
        rec.max_gap  = all_max_q;
        rec.count_a  = layers_q;
        rec.count_b  = clean_q;
        rec.count_c  = all_gaps_q;
      end
      default: begin
        rec.kind = sel;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (pop_o) begin
            pend_q <= {job_i.finish, job_i.finish, job_i.close, job_i.rev,
                       job_i.plunge, job_i.retract, job_i.zjump, job_i.gap};
            st_q   <= job_i.gap ? ST_GAP_RT : ST_EMIT;
          end
        end
        ST_GAP_RT: begin
          if (sq_done) begin
            st_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (pend_q == '0) begin
            st_q <= job_q.lgap ? ST_XY_RT : ST_IDLE;
          end else if (emit) begin
            pend_q <= pend_rest;
          end
        end
        ST_XY_RT: begin
          if (sq_done) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= rec;
    end
  end

  // Running tallies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lay_gaps_q  <= '0;
      lay_max_q   <= '0;
      lay_sum_q   <= '0;
      high_q      <= '0;
      med_q       <= '0;
      low_q       <= '0;
      rapid_sum_q <= '0;
      layers_q    <= '0;
      clean_q     <= '0;
      all_gaps_q  <= '0;
      all_max_q   <= '0;
    end else if (emit) begin
      case (sel)
        tcc_pkg::KIND_GAP, tcc_pkg::KIND_ZJUMP, tcc_pkg::KIND_RETRACT,
        tcc_pkg::KIND_PLUNGE, tcc_pkg::KIND_REVERSAL: begin
          if (rec.severity == tcc_pkg::SEV_HIGH) begin
            high_q <= tcc_pkg::sat_inc(high_q);
          end else if (rec.severity == tcc_pkg::SEV_MED) begin
            med_q <= tcc_pkg::sat_inc(med_q);
          end else begin
            low_q <= tcc_pkg::sat_inc(low_q);
          end
          if (sel == tcc_pkg::KIND_GAP) begin
            rapid_sum_q <= tcc_pkg::sat_sum(rapid_sum_q, SB'(root));
          end
        end
        tcc_pkg::KIND_LAYER: begin
          layers_q <= tcc_pkg::sat_inc(layers_q);
          if (lay_gaps_q == '0) begin
            clean_q <= tcc_pkg::sat_inc(clean_q);
          end
          all_gaps_q <= gap_add[CB] ? '1 : gap_add[CB-1:0];
          if (lay_max_q > all_max_q) begin
            all_max_q <= lay_max_q;
          end
          lay_gaps_q <= '0;
          lay_max_q  <= '0;
          lay_sum_q  <= '0;
        end
        tcc_pkg::KIND_LAYER_TALLY: begin
          lay_gaps_q  <= '0;
          lay_max_q   <= '0;
          lay_sum_q   <= '0;
          high_q      <= '0;
          med_q       <= '0;
          low_q       <= '0;
          rapid_sum_q <= '0;
          layers_q    <= '0;
          clean_q     <= '0;
          all_gaps_q  <= '0;
          all_max_q   <= '0;
        end
        default: begin
          layers_q <= layers_q;
        end
      endcase
    end else if (st_q == ST_XY_RT && sq_done) begin
      lay_gaps_q <= tcc_pkg::sat_inc(lay_gaps_q);
      if (g > lay_max_q) begin
        lay_max_q <= g;
      end
      lay_sum_q <= tcc_pkg::sat_sum(lay_sum_q, SB'(g));
    end
  end

endmodule

// File: rtl/core/toolpath_continuity_checker.sv
// Toolpath continuity checker: takes parsed motion moves in micrometres and
// reports, per move in this order, rapid gaps, Z jumps, retractions, plunges and
// XY direction reversals, plus one record for each finished layer; a finish
// request flushes the open layer and reports the issue tally (with score) and
// the layer tally, then clears all tracking state. In the front each move is
// accepted into the classify stage, then pushed into the job queue. The back
// pops a job when idle, then emits its result records while the output register
// is free and takes a closing step. The bit-serial square root runs before the
// records of a rapid gap for its length and after the closing step of a linear
// feed over the layer threshold for the layer gap length, so no move needs both.
// A move yields at most four records. The queue holds four jobs, so the front
// keeps accepting while a result waits at the output until queue and stage fill.
// The user must see that thresholds are written through the cfg port only
// while the block is idle; the block itself does not enforce this.
// Depends on tcc_pkg, tcc_if, tcc_front, tcc_queue, tcc_sqrt and tcc_back.
module toolpath_continuity_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [tcc_pkg::THR_BITS-1:0]       cfg_data_i,
  tcc_in_if.sink                             in_i,
  tcc_out_if.source                          out_o
);
  localparam int unsigned TB = tcc_pkg::THR_BITS;

  logic [TB-1:0]   gap_thr_q, layer_thr_q;
  logic [2*TB-1:0] gap_thr_sq_q, layer_thr_sq_q;
  logic            push, full, pop, empty;
  tcc_pkg::job_t   job_in, job_out;

  // Hold the thresholds; register their squares for exact length tests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_thr_q   <= tcc_pkg::GAP_THR_RST;
      layer_thr_q <= tcc_pkg::LAYER_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcc_pkg::CFG_GAP_THR:   gap_thr_q   <= cfg_data_i;
        tcc_pkg::CFG_LAYER_THR: layer_thr_q <= cfg_data_i;
        default:                gap_thr_q   <= gap_thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    gap_thr_sq_q   <= gap_thr_q * gap_thr_q;
    layer_thr_sq_q <= layer_thr_q * layer_thr_q;
  end

  // Front: accept and classify each request
  tcc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .gap_thr_sq_i   (gap_thr_sq_q),
    .layer_thr_sq_i (layer_thr_sq_q),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  // Queue: decouple classification from reporting
  tcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // Back: take roots, advance tallies, drive result records
  tcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_out),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
